[rtl/qap_pkg.sv]
package qap_pkg;

  localparam int MaxSize    = 32;
  localparam int IdxBits    = 5;
  localparam int EntryBits  = 16;
  localparam int CostBits   = 42;
  localparam int SumBits    = 43;
  localparam int RngBits    = 48;
  localparam int AddrBits   = 2 * IdxBits;

  localparam logic [15:0] SeedLow = 16'h330e;
  localparam logic [RngBits-1:0] LcgMul = 48'h0005_deec_e66d;
  localparam logic [RngBits-1:0] LcgAdd = 48'h0000_0000_000b;
  localparam logic [SumBits-1:0] SumCap = {SumBits{1'b1}};

  typedef enum logic [2:0] {
    OP_LOAD_FLOW = 3'd0,
    OP_LOAD_DIST = 3'd1,
    OP_LOAD_ASSIGN = 3'd2,
    OP_EVALUATE = 3'd3,
    OP_EXCHANGE = 3'd4
  } opcode_t;

  localparam logic [1:0] RegSize   = 2'd0;
  localparam logic [1:0] RegTarget = 2'd1;
  localparam logic [1:0] RegSeed   = 2'd2;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [IdxBits-1:0]   row_index;
    logic [IdxBits-1:0]   col_index;
    logic [15:0]          entry_value;
    logic [CostBits-1:0]  start_cost;
  } cmd_t;

  typedef struct packed {
    logic [CostBits-1:0]  result_cost;
    logic                 swap_made;
    logic [IdxBits-1:0]   first_facility;
    logic [IdxBits-1:0]   second_facility;
    logic                 target_reached;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_EVAL,
    ST_EVAL_END,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_COST,
    ST_DECIDE,
    ST_RNG,
    ST_UNSWAP_A,
    ST_UNSWAP_B,
    ST_NEXT,
    ST_APPLY_A,
    ST_APPLY_B,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                start;
    logic [IdxBits-1:0]  size_m1;
  } cost_ctl_t;

endpackage

[rtl/qap_cost_unit.sv]
module qap_cost_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  qap_pkg::cost_ctl_t              ctl,
  output logic [qap_pkg::AddrBits-1:0]    flow_addr,
  output logic [qap_pkg::IdxBits-1:0]     asg_addr_i,
  output logic [qap_pkg::IdxBits-1:0]     asg_addr_j,
  input  logic [qap_pkg::IdxBits-1:0]     loc_i,
  input  logic [qap_pkg::IdxBits-1:0]     loc_j,
  output logic [qap_pkg::AddrBits-1:0]    dist_addr,
  input  logic [qap_pkg::EntryBits-1:0]   flow_rd,
  input  logic [qap_pkg::EntryBits-1:0]   dist_rd,
  output logic                            done,
  output logic [qap_pkg::CostBits-1:0]    cost
);
  import qap_pkg::*;

  // Stage 0: walk (i,j). Stage 1: read assignment. Stage 2: read matrices.
  // Stage 3: multiply. Stage 4: saturating accumulate.
  logic                 run;
  logic [IdxBits-1:0]   ci, cj;
  logic [AddrBits-1:0]  flow_addr_q;
  logic                 v1, v2, v3, last1, last2, last3;
  logic [2*EntryBits-1:0] prod;
  logic [SumBits-1:0]   acc;
  logic [SumBits-1:0]   room;
  logic                 fin;

  assign asg_addr_i = ci;
  assign asg_addr_j = cj;
  assign flow_addr  = flow_addr_q;
  assign dist_addr  = {loc_i, loc_j};
  assign room       = SumCap - acc;
  assign cost       = acc[SumBits-1:1];
  assign done       = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      fin <= 1'b0;
      ci <= '0;
      cj <= '0;
    end else begin
      fin <= v3 && last3;
      v1 <= run;
      last1 <= run && ci == ctl.size_m1 && cj == ctl.size_m1;
      v2 <= v1;
      last2 <= last1;
      v3 <= v2;
      last3 <= last2;
      if (ctl.start) begin
        run <= 1'b1;
        ci <= '0;
        cj <= '0;
      end else if (run) begin
        if (cj == ctl.size_m1) begin
          cj <= '0;
          if (ci == ctl.size_m1) begin
            run <= 1'b0;
          end else begin
            ci <= ci + 1'b1;
          end
        end else begin
          cj <= cj + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    flow_addr_q <= {ci, cj};
    prod <= flow_rd * dist_rd;
    if (ctl.start) begin
      acc <= '0;
    end else if (v3) begin
      if (SumBits'(prod) >= room) begin
        acc <= SumCap;
      end else begin
        acc <= acc + SumBits'(prod);
      end
    end
  end

endmodule

[rtl/qap_two_exchange_search.sv]
// Command-driven quadratic assignment search. Loads (opcodes 0 to 2) give no
// result. Evaluate walks all n*n facility pairs through one pipelined
// multiply-accumulate; busy stays high until it ends, and the result appears
// as busy drops. An exchange pass runs a full evaluation for each of the
// n*(n-1)/2 pairs, makes a random draw when the cost ties the best so far,
// and applies the chosen swap, if any, before it finishes; reaching the target
// cost ends it early. busy stays high while an evaluation or exchange runs and
// drops as the single result is shown on result with done for one cycle; the
// receiver cannot stall it, so it must take every done strobe. Write the
// configuration registers only while busy is low.
module qap_two_exchange_search (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  qap_pkg::cmd_t     cmd,
  output logic              done,
  output qap_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import qap_pkg::*;

  logic [EntryBits-1:0] flow_mem [MaxSize*MaxSize];
  logic [EntryBits-1:0] dist_mem [MaxSize*MaxSize];
  logic [IdxBits-1:0]   asg_mem  [MaxSize];

  logic [5:0]          size_in_use;
  logic [CostBits-1:0] target_cost;
  logic [31:0]         rng_seed;
  logic [RngBits-1:0]  rng_state;
  logic [RngBits-1:0]  rng_acc;
  logic [1:0]          rng_phase;

  state_t state, state_next;
  cmd_t   cur;
  logic [IdxBits-1:0] fi, fj, bi, bj, size_m1;
  logic [CostBits-1:0] best;
  logic changed;
  logic hit;
  logic [IdxBits-1:0] tmp_a;

  cost_ctl_t ctl;
  logic [AddrBits-1:0] flow_addr, dist_addr;
  logic [IdxBits-1:0]  aai, aaj, loc_i, loc_j;
  logic [EntryBits-1:0] flow_rd, dist_rd;
  logic cost_done;
  logic [CostBits-1:0] cost;
  logic cfg_wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];
  assign busy    = state != ST_IDLE;

  always_comb begin
    if (size_in_use < 6'd2) begin
      size_m1 = IdxBits'(1);
    end else if (size_in_use > 6'(MaxSize)) begin
      size_m1 = IdxBits'(MaxSize - 1);
    end else begin
      size_m1 = IdxBits'(size_in_use - 6'd1);
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegSize:   prdata = 64'(size_in_use);
      RegTarget: prdata = 64'(target_cost);
      RegSeed:   prdata = 64'(rng_seed);
      default:   prdata = '0;
    endcase
  end

  assign ctl.size_m1 = size_m1;
  assign ctl.start = (start && !busy && cmd.opcode == OP_EVALUATE) ||
                     state == ST_SWAP_B;

  qap_cost_unit u_cost (
    .clk(clk), .rst(rst), .ctl(ctl),
    .flow_addr(flow_addr), .asg_addr_i(aai), .asg_addr_j(aaj),
    .loc_i(loc_i), .loc_j(loc_j), .dist_addr(dist_addr),
    .flow_rd(flow_rd), .dist_rd(dist_rd),
    .done(cost_done), .cost(cost)
  );

  always_ff @(posedge clk) begin
    loc_i <= asg_mem[aai];
    loc_j <= asg_mem[aaj];
    flow_rd <= flow_mem[flow_addr];
    dist_rd <= dist_mem[dist_addr];
  end

  // Matrix and assignment writes; each swap spans an A state then a B state.
  always_ff @(posedge clk) begin
    if (start && !busy && cmd.opcode == OP_LOAD_FLOW) begin
      flow_mem[{cmd.row_index, cmd.col_index}] <= cmd.entry_value;
    end
    if (start && !busy && cmd.opcode == OP_LOAD_DIST) begin
      dist_mem[{cmd.row_index, cmd.col_index}] <= cmd.entry_value;
    end
    if (start && !busy && cmd.opcode == OP_LOAD_ASSIGN) begin
      asg_mem[cmd.row_index] <= cmd.entry_value[IdxBits-1:0];
    end
    if (state == ST_SWAP_A || state == ST_UNSWAP_A) begin
      tmp_a <= asg_mem[fi];
      asg_mem[fi] <= asg_mem[fj];
    end
    if (state == ST_APPLY_A) begin
      tmp_a <= asg_mem[bi];
      asg_mem[bi] <= asg_mem[bj];
    end
    if (state == ST_SWAP_B || state == ST_UNSWAP_B) begin
      asg_mem[fj] <= tmp_a;
    end
    if (state == ST_APPLY_B) begin
      asg_mem[bj] <= tmp_a;
    end
  end

  // The generator step is built from three partial products, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= 6'd32;
      target_cost <= '0;
      rng_seed <= '0;
      rng_state <= {16'd0, 16'd0, SeedLow};
      rng_acc <= '0;
      rng_phase <= '0;
    end else begin
      if (state == ST_DECIDE) begin
        rng_phase <= '0;
      end
      if (state == ST_RNG) begin
        rng_phase <= rng_phase + 1'b1;
        case (rng_phase)
          2'd0: rng_acc <= rng_state * LcgMul[15:0] + LcgAdd;
          2'd1: rng_acc <= rng_acc + {rng_state[31:0] * LcgMul[31:16], 16'd0};
          2'd2: rng_acc <= rng_acc + {rng_state[15:0] * LcgMul[47:32], 32'd0};
          default: rng_state <= rng_acc;
        endcase
      end
      if (cfg_wr) begin
        unique case (reg_idx)
          RegSize:   size_in_use <= pwdata[5:0];
          RegTarget: target_cost <= pwdata[CostBits-1:0];
          RegSeed: begin
            rng_seed <= pwdata[31:0];
            rng_state <= {pwdata[31:0], SeedLow};
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd.opcode == OP_EVALUATE) begin
            state_next = ST_EVAL;
          end else if (cmd.opcode == OP_EXCHANGE) begin
            state_next = ST_SWAP_A;
          end
        end
      end
      ST_EVAL:     state_next = cost_done ? ST_EVAL_END : ST_EVAL;
      ST_EVAL_END: state_next = ST_IDLE;
      ST_SWAP_A:   state_next = ST_SWAP_B;
      ST_SWAP_B:   state_next = ST_COST;
      ST_COST:     state_next = cost_done ? ST_DECIDE : ST_COST;
      ST_DECIDE: begin
        if (cost == target_cost) begin
          state_next = ST_DONE;
        end else if (cost == best) begin
          state_next = ST_RNG;
        end else begin
          state_next = ST_UNSWAP_A;
        end
      end
      ST_RNG:      state_next = (rng_phase == 2'd3) ? ST_UNSWAP_A : ST_RNG;
      ST_UNSWAP_A: state_next = ST_UNSWAP_B;
      ST_UNSWAP_B: state_next = ST_NEXT;
      ST_NEXT: begin
        if (fj == size_m1 && fi == size_m1 - 1'b1) begin
          state_next = changed ? ST_APPLY_A : ST_DONE;
        end else begin
          state_next = ST_SWAP_A;
        end
      end
      ST_APPLY_A:  state_next = ST_APPLY_B;
      ST_APPLY_B:  state_next = ST_DONE;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
      changed <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          cur <= cmd;
          best <= cmd.start_cost;
          changed <= 1'b0;
          fi <= '0;
          fj <= IdxBits'(1);
          bi <= '0;
          bj <= '0;
        end
        ST_EVAL_END: begin
          done <= 1'b1;
          result <= '{cost, 1'b0, '0, '0, 1'b0};
        end
        ST_DECIDE: begin
          if (cost == target_cost) begin
            best <= cost;
            changed <= 1'b1;
            bi <= fi;
            bj <= fj;
          end else if (cost < best) begin
            best <= cost;
            changed <= 1'b1;
            bi <= fi;
            bj <= fj;
          end
        end
        ST_RNG: begin
          if (rng_phase == 2'd3 && rng_acc[17]) begin
            changed <= 1'b1;
            bi <= fi;
            bj <= fj;
          end
        end
        ST_NEXT: begin
          if (fj == size_m1) begin
            fi <= fi + 1'b1;
            fj <= fi + 2'd2;
          end else begin
            fj <= fj + 1'b1;
          end
        end
        ST_DONE: begin
          done <= 1'b1;
          result <= '{best, changed, changed ? bi : '0, changed ? bj : '0,
                      changed && cur.opcode == OP_EXCHANGE && best == target_cost &&
                      state_next == ST_IDLE && hit};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (state == ST_IDLE) begin
      hit <= 1'b0;
    end else if (state == ST_DECIDE && cost == target_cost) begin
      hit <= 1'b1;
    end
  end

endmodule
